FILE: rtl/pfc_pkg.sv
// Shared types, constants and square helpers for the Playfair cipher core.
`default_nettype none
package pfc_pkg;

	localparam int CodeW   = 5;
	localparam int PosW    = 3;
	localparam int AsciiW  = 7;
	localparam int ByteW   = 8;
	localparam int RowW    = 25;
	localparam int SideN   = 5;
	localparam int CfgIdxW = 3;
	localparam int QDepth  = 4;
	localparam int QAw     = $clog2(QDepth);
	localparam int QCntW   = $clog2(QDepth + 1);

	localparam logic [CodeW-1:0] CODE_X   = 5'd23;
	localparam logic [CodeW-1:0] CODE_I   = 5'd8;
	localparam logic [CodeW-1:0] CODE_J   = 5'd9;
	localparam logic [CodeW-1:0] CODE_MAX = 5'd25;

	localparam logic [ByteW-1:0] ASCII_UP_A = 8'd65;
	localparam logic [ByteW-1:0] ASCII_LO_A = 8'd97;
	localparam logic [AsciiW-1:0] ASCII_A7  = 7'd97;
	localparam logic [AsciiW-1:0] ASCII_Z7  = 7'd122;

	localparam logic [CfgIdxW-1:0] REG_DECRYPT = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ROW0    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ROW1    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ROW2    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ROW3    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_ROW4    = 3'd5;

	localparam logic [RowW-1:0] ROW0_RST = 25'd4294688;
	localparam logic [RowW-1:0] ROW1_RST = 25'd10755269;
	localparam logic [RowW-1:0] ROW2_RST = 25'd16201099;
	localparam logic [RowW-1:0] ROW3_RST = 25'd21613104;
	localparam logic [RowW-1:0] ROW4_RST = 25'd27025109;

	typedef logic [SideN-1:0][RowW-1:0] square_t;

	typedef struct packed {
		logic    decrypt;
		square_t square;
	} cfg_t;

	typedef struct packed {
		logic [CodeW-1:0] a;
		logic [CodeW-1:0] b;
		logic             last;
		logic             end_only;
	} job_t;

	function automatic logic [CodeW-1:0] sq_cell(square_t sq, logic [PosW-1:0] r,
			logic [PosW-1:0] c);
		logic [CodeW-1:0] v;
		v = '0;
		for (int i = 0; i < SideN; i++) begin
			for (int k = 0; k < SideN; k++) begin
				if (r == PosW'(i) && c == PosW'(k))
					v = sq[i][CodeW*k +: CodeW];
			end
		end
		return v;
	endfunction

	// first occurrence in row-major order wins; missing code sits at row 0, column 0
	function automatic logic [2*PosW-1:0] locate(square_t sq, logic [CodeW-1:0] code);
		logic [2*PosW-1:0] pos;
		pos = '0;
		for (int i = SideN - 1; i >= 0; i--) begin
			for (int k = SideN - 1; k >= 0; k--) begin
				if (sq[i][CodeW*k +: CodeW] == code)
					pos = {PosW'(i), PosW'(k)};
			end
		end
		return pos;
	endfunction

	function automatic logic [PosW-1:0] add_mod5(logic [PosW-1:0] x, logic [PosW-1:0] inc);
		logic [PosW:0] s;
		s = {1'b0, x} + {1'b0, inc};
		if (s >= (PosW+1)'(SideN))
			s = s - (PosW+1)'(SideN);
		return s[PosW-1:0];
	endfunction

	function automatic logic [AsciiW-1:0] to_ascii(logic [CodeW-1:0] code);
		return (code > CODE_MAX) ? ASCII_Z7 : ASCII_A7 + AsciiW'(code);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/pfc_fifo.sv
// Short job queue between the front and back parts.
`default_nettype none
module pfc_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire pfc_pkg::job_t   push_data,
	output logic                 full,
	input  wire                  pop,
	output pfc_pkg::job_t        pop_data,
	output logic                 empty
);

	pfc_pkg::job_t                  mem_q [pfc_pkg::QDepth];
	logic [pfc_pkg::QAw-1:0]        wr_ptr_q;
	logic [pfc_pkg::QAw-1:0]        rd_ptr_q;
	logic [pfc_pkg::QCntW-1:0]      cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full     = (cnt_q == pfc_pkg::QCntW'(pfc_pkg::QDepth));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pfc_front.sv
// Front part: normalizes bytes, inserts fillers when encrypting, forms letter pairs into jobs.
`default_nettype none
module pfc_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          decrypt,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire [pfc_pkg::ByteW-1:0]     in_byte,
	input  wire                          msg_end,
	output logic                         push,
	output pfc_pkg::job_t                push_data,
	input  wire                          full
);

	logic [pfc_pkg::CodeW-1:0] held_letter_q;
	logic                      held_valid_q;
	logic [pfc_pkg::CodeW-1:0] pair_first_q;
	logic                      pair_half_q;
	logic                      pend_valid_q;
	pfc_pkg::job_t             pend_q;

	logic                      accept;
	logic                      is_up;
	logic                      is_lo;
	logic                      is_letter;
	logic [pfc_pkg::ByteW-1:0] diff;
	logic [pfc_pkg::CodeW-1:0] code;
	logic [pfc_pkg::CodeW-1:0] feed [4];
	logic [2:0]                nf;
	logic                      hv_new;
	logic [pfc_pkg::CodeW-1:0] hl_new;
	logic                      half;
	logic [pfc_pkg::CodeW-1:0] first;
	pfc_pkg::job_t             job0;
	pfc_pkg::job_t             job1;
	logic [1:0]                nj;

	assign accept   = in_valid && in_ready;
	assign in_ready = !pend_valid_q && !full;

	always_comb begin
		is_up     = in_byte inside {[8'd65:8'd90]};
		is_lo     = in_byte inside {[8'd97:8'd122]};
		is_letter = is_up || is_lo;
		diff      = is_up ? (in_byte - pfc_pkg::ASCII_UP_A) :
		            is_lo ? (in_byte - pfc_pkg::ASCII_LO_A) : '0;
		code      = diff[pfc_pkg::CodeW-1:0];
		if (code == pfc_pkg::CODE_J)
			code = pfc_pkg::CODE_I;

		for (int i = 0; i < 4; i++)
			feed[i] = pfc_pkg::CODE_X;
		nf     = '0;
		hv_new = held_valid_q;
		hl_new = held_letter_q;
		if (decrypt) begin
			hv_new = 1'b0;
			if (is_letter) begin
				feed[0] = code;
				nf      = 3'd1;
			end
		end else begin
			if (is_letter) begin
				if (held_valid_q) begin
					feed[0] = held_letter_q;
					nf      = 3'd1;
					if (held_letter_q == code) begin
						feed[1] = pfc_pkg::CODE_X;
						nf      = 3'd2;
					end
				end
				hv_new = 1'b1;
				hl_new = code;
			end
			if (msg_end) begin
				if (hv_new) begin
					feed[nf[1:0]] = hl_new;
					nf            = nf + 3'd1;
				end
				// pad an odd count
				if (pair_half_q ^ nf[0]) begin
					feed[nf[1:0]] = pfc_pkg::CODE_X;
					nf            = nf + 3'd1;
				end
			end
		end

		half  = pair_half_q;
		first = pair_first_q;
		job0  = '0;
		job1  = '0;
		nj    = '0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < nf) begin
				if (!half) begin
					first = feed[i];
					half  = 1'b1;
				end else begin
					if (nj == 2'd0) begin
						job0.a = first;
						job0.b = feed[i];
					end else begin
						job1.a = first;
						job1.b = feed[i];
					end
					nj   = nj + 2'd1;
					half = 1'b0;
				end
			end
		end

		if (msg_end) begin
			if (nj == 2'd0) begin
				job0.end_only = 1'b1;
				job0.last     = 1'b1;
				nj            = 2'd1;
			end else if (nj == 2'd1) begin
				job0.last = 1'b1;
			end else begin
				job1.last = 1'b1;
			end
		end
	end

	assign push      = pend_valid_q || (accept && nj != 2'd0);
	assign push_data = pend_valid_q ? pend_q : job0;

	always_ff @(posedge clk) begin
		if (accept && nj == 2'd2)
			pend_q <= job1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
			pair_first_q  <= '0;
			pair_half_q   <= 1'b0;
			pend_valid_q  <= 1'b0;
		end else begin
			if (pend_valid_q && !full)
				pend_valid_q <= 1'b0;
			if (accept) begin
				pend_valid_q <= (nj == 2'd2);
				if (msg_end) begin
					held_letter_q <= '0;
					held_valid_q  <= 1'b0;
					pair_first_q  <= '0;
					pair_half_q   <= 1'b0;
				end else begin
					held_letter_q <= hl_new;
					held_valid_q  <= hv_new;
					pair_first_q  <= first;
					pair_half_q   <= half;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/pfc_back.sv
// Back part: locates pair letters in the square, applies the rule, emits letters.
`default_nettype none
module pfc_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire pfc_pkg::cfg_t           cfg,
	input  wire                          q_empty,
	input  wire pfc_pkg::job_t           q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [pfc_pkg::AsciiW-1:0]   out_letter,
	output logic                         end_only,
	output logic                         last_out
);

	logic                      valid_s1;
	logic [pfc_pkg::PosW-1:0]  r1_s1;
	logic [pfc_pkg::PosW-1:0]  c1_s1;
	logic [pfc_pkg::PosW-1:0]  r2_s1;
	logic [pfc_pkg::PosW-1:0]  c2_s1;
	logic                      last_s1;
	logic                      eo_s1;

	logic [pfc_pkg::AsciiW-1:0] cur_q;
	logic [pfc_pkg::AsciiW-1:0] nxt_q;
	logic [1:0]                 cnt_q;
	logic                       eo_q;
	logic                       last_q;

	logic [2*pfc_pkg::PosW-1:0] pos_a;
	logic [2*pfc_pkg::PosW-1:0] pos_b;
	logic                       take_s1;
	logic                       load;
	logic                       xfer;
	logic [pfc_pkg::PosW-1:0]   inc;
	logic [pfc_pkg::CodeW-1:0]  o1;
	logic [pfc_pkg::CodeW-1:0]  o2;

	assign pos_a   = pfc_pkg::locate(cfg.square, q_data.a);
	assign pos_b   = pfc_pkg::locate(cfg.square, q_data.b);
	assign xfer    = out_valid && out_ready;
	assign load    = valid_s1 && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_ready));
	assign take_s1 = !valid_s1 || load;
	assign q_pop   = take_s1 && !q_empty;
	assign inc     = cfg.decrypt ? 3'd4 : 3'd1;

	always_comb begin
		if (r1_s1 == r2_s1) begin
			o1 = pfc_pkg::sq_cell(cfg.square, r1_s1, pfc_pkg::add_mod5(c1_s1, inc));
			o2 = pfc_pkg::sq_cell(cfg.square, r2_s1, pfc_pkg::add_mod5(c2_s1, inc));
		end else if (c1_s1 == c2_s1) begin
			o1 = pfc_pkg::sq_cell(cfg.square, pfc_pkg::add_mod5(r1_s1, inc), c1_s1);
			o2 = pfc_pkg::sq_cell(cfg.square, pfc_pkg::add_mod5(r2_s1, inc), c2_s1);
		end else begin
			o1 = pfc_pkg::sq_cell(cfg.square, r1_s1, c2_s1);
			o2 = pfc_pkg::sq_cell(cfg.square, r2_s1, c1_s1);
		end
	end

	assign out_valid  = (cnt_q != 2'd0);
	assign out_letter = cur_q;
	assign end_only   = eo_q;
	assign last_out   = last_q && (cnt_q == 2'd1);

	always_ff @(posedge clk) begin
		if (take_s1 && !q_empty) begin
			{r1_s1, c1_s1} <= pos_a;
			{r2_s1, c2_s1} <= pos_b;
			last_s1        <= q_data.last;
			eo_s1          <= q_data.end_only;
		end
		if (load) begin
			cur_q  <= eo_s1 ? '0 : pfc_pkg::to_ascii(o1);
			nxt_q  <= pfc_pkg::to_ascii(o2);
			eo_q   <= eo_s1;
			last_q <= last_s1;
		end else if (xfer) begin
			cur_q <= nxt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (take_s1)
				valid_s1 <= !q_empty;
			if (load)
				cnt_q <= eo_s1 ? 2'd1 : 2'd2;
			else if (xfer)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/playfair_cipher_core.sv
// Top level of the Playfair cipher core: registers, front, queue and back.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid in_ready in_byte msg_end    | to core
//  out     | out_valid out_ready out_letter       | from core
//          | end_only last_out                    |
//  cfg     | cfg_valid cfg_ready cfg_index        | to core
//          | cfg_data                             |
//
// The front takes one byte per cycle while the queue has room; a byte that
// closes two pairs holds off the next byte until its second job is queued.
// The back emits one letter per cycle while out_ready is high, two per pair.
// A four-entry job queue lets either side stall on its own. Reset clears the
// square to a..z without j and selects encrypt mode. cfg_ready is always high.
`default_nettype none
module playfair_cipher_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [pfc_pkg::ByteW-1:0]       in_byte,
	input  wire                            msg_end,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [pfc_pkg::AsciiW-1:0]     out_letter,
	output logic                           end_only,
	output logic                           last_out,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [pfc_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire [pfc_pkg::RowW-1:0]        cfg_data
);

	pfc_pkg::cfg_t cfg_q;
	pfc_pkg::job_t push_data;
	pfc_pkg::job_t pop_data;
	logic          push;
	logic          full;
	logic          pop;
	logic          empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decrypt   <= 1'b0;
			cfg_q.square[0] <= pfc_pkg::ROW0_RST;
			cfg_q.square[1] <= pfc_pkg::ROW1_RST;
			cfg_q.square[2] <= pfc_pkg::ROW2_RST;
			cfg_q.square[3] <= pfc_pkg::ROW3_RST;
			cfg_q.square[4] <= pfc_pkg::ROW4_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfc_pkg::REG_DECRYPT: cfg_q.decrypt   <= cfg_data[0];
				pfc_pkg::REG_ROW0:    cfg_q.square[0] <= cfg_data;
				pfc_pkg::REG_ROW1:    cfg_q.square[1] <= cfg_data;
				pfc_pkg::REG_ROW2:    cfg_q.square[2] <= cfg_data;
				pfc_pkg::REG_ROW3:    cfg_q.square[3] <= cfg_data;
				pfc_pkg::REG_ROW4:    cfg_q.square[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	pfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.decrypt   (cfg_q.decrypt),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.msg_end   (msg_end),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	pfc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	pfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_letter (out_letter),
		.end_only   (end_only),
		.last_out   (last_out)
	);

endmodule
`default_nettype wire

FILE: rtl/pfc_checker.sv
// Port-level checks for the Playfair cipher core and their bind.
`default_nettype none
module pfc_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_valid,
	input wire                         in_ready,
	input wire [pfc_pkg::ByteW-1:0]    in_byte,
	input wire                         msg_end,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire [pfc_pkg::AsciiW-1:0]   out_letter,
	input wire                         end_only,
	input wire                         last_out
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(msg_end))
		else $error("input changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_letter)
			&& $stable(end_only) && $stable(last_out))
		else $error("output changed while stalled");

	a_end_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_only |-> last_out && out_letter == '0)
		else $error("end marker without last or with a letter");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_only |-> out_letter >= pfc_pkg::ASCII_A7
			&& out_letter <= pfc_pkg::ASCII_Z7)
		else $error("letter out of range");

	a_last_then_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_out |=> !(out_valid && end_only && !last_out))
		else $error("end marker not flagged last");

endmodule

bind playfair_cipher_core pfc_checker u_pfc_checker (.*);
`default_nettype wire
